// ----- rtl/lvnt_pkg.sv -----
// lvnt_pkg: shared types, codes and the per-lookup step table
// used by lvnt_ctrl, lvnt_datapath and the top level
package lvnt_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_OCTAVE_COUNT = 1'b0;
  localparam logic REG_VECTOR_MODE  = 1'b1;

  localparam int StoreDepth = 4096;
  localparam int WrapSteps  = 1;
  localparam int SmoothSteps = 6;
  localparam int LookSteps  = 24;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_FIX,
    ST_SMOOTH,
    ST_LOOK,
    ST_ADV,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_RD,
    OP_LZ,
    OP_LY,
    OP_LX,
    OP_ACC
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] corner;
  } step_t;

  typedef struct packed {
    logic        wr_en;
    logic        clr_en;
    logic [11:0] clr_addr;
    logic        load;
    logic        wrap_step;
    logic        wrap_fin;
    logic        sm_stage1;
    logic        sm_stage2;
    logic [1:0]  sm_axis;
    op_e         op;
    logic [2:0]  corner;
    logic [1:0]  look;
    logic [3:0]  oct;
    logic        advance;
    logic        out_load;
  } ctl_t;

  // reads interleave with blends so that no two stack updates land together
  function automatic step_t look_step(input logic [4:0] idx);
    step_t s;
    s.op     = OP_NOP;
    s.corner = 3'd0;
    case (idx)
      5'd0:  begin s.op = OP_RD; s.corner = 3'd0; end
      5'd1:  begin s.op = OP_RD; s.corner = 3'd1; end
      5'd3:  s.op = OP_LZ;
      5'd4:  begin s.op = OP_RD; s.corner = 3'd2; end
      5'd5:  begin s.op = OP_RD; s.corner = 3'd3; end
      5'd7:  s.op = OP_LZ;
      5'd9:  s.op = OP_LY;
      5'd10: begin s.op = OP_RD; s.corner = 3'd4; end
      5'd11: begin s.op = OP_RD; s.corner = 3'd5; end
      5'd13: s.op = OP_LZ;
      5'd14: begin s.op = OP_RD; s.corner = 3'd6; end
      5'd15: begin s.op = OP_RD; s.corner = 3'd7; end
      5'd17: s.op = OP_LZ;
      5'd19: s.op = OP_LY;
      5'd21: s.op = OP_LX;
      5'd23: s.op = OP_ACC;
      default: s.op = OP_NOP;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/lattice_value_noise_turbulence_unit.sv -----
// Value-noise turbulence over a cubic lattice held in a 4096-entry memory.
// A write is stored in the cycle it is accepted. A query runs N octaves, N the
// octave count (capped at MAX_OCTAVES), with one lookup per octave in scalar
// mode and three in vector mode; the next transaction can be taken from the
// cycle in which the result is raised. The single lattice read port and one
// shared blend multiplier handle eight reads and seven blends per lookup,
// smoothing is computed for each axis in turn, an octave step follows the
// lookups, and a reciprocal multiply wraps the point. A finished result
// waits until the previous one is taken. After reset a clearing pass over
// all 4096 entries runs before the first transaction is taken. Depends on
// lvnt_pkg, lvnt_ctrl and lvnt_datapath.
module lattice_value_noise_turbulence_unit import lvnt_pkg::*; #(
  parameter int LATTICE_SIZE = 16,
  parameter int MAX_OCTAVES  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [11:0]        entry_index_i,
  input  logic [15:0]        entry_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [16:0]        value_x_o,
  output logic [16:0]        value_y_o,
  output logic [16:0]        value_z_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [4:0]         cfg_data_i
);

  ctl_t ctl;

  lvnt_ctrl #(
    .MAX_OCTAVES(MAX_OCTAVES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_o       (ctl)
  );

  lvnt_datapath #(
    .LATTICE_SIZE(LATTICE_SIZE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .value_x_o     (value_x_o),
    .value_y_o     (value_y_o),
    .value_z_o     (value_z_o)
  );

endmodule

// ----- rtl/lvnt_ctrl.sv -----
// lvnt_ctrl: sequencer for clearing, writes, octave and lookup loops,
// plus the configuration registers; depends on lvnt_pkg
module lvnt_ctrl import lvnt_pkg::*; #(
  parameter int MAX_OCTAVES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [4:0] cfg_data_i,
  output ctl_t       ctl_o
);

  localparam logic [4:0] MaxOct = 5'(MAX_OCTAVES);

  state_e      state_q, state_d;
  logic [4:0]  step_q, step_d;
  logic [1:0]  look_q, look_d;
  logic [3:0]  oct_q, oct_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [11:0] clr_q, clr_d;
  logic        out_valid_q, out_valid_d;
  logic [4:0]  oct_cfg_q;
  logic        vec_cfg_q;
  logic [4:0]  cnt_cap;
  logic [1:0]  last_look;
  logic        in_acc;
  step_t       st;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cnt_cap     = (oct_cfg_q > MaxOct) ? MaxOct : oct_cfg_q;
  assign last_look   = vec_cfg_q ? 2'd2 : 2'd0;
  assign st          = look_step(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_cfg_q <= 5'd4;
      vec_cfg_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_OCTAVE_COUNT: oct_cfg_q <= cfg_data_i;
        REG_VECTOR_MODE:  vec_cfg_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= '0;
      look_q      <= '0;
      oct_q       <= '0;
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      look_q      <= look_d;
      oct_q       <= oct_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    look_d      = look_q;
    oct_d       = oct_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    ctl_o           = '0;
    ctl_o.op        = OP_NOP;
    ctl_o.clr_addr  = clr_q;
    ctl_o.sm_axis   = step_q[2:1];
    ctl_o.corner    = st.corner;
    ctl_o.look      = look_q;
    ctl_o.oct       = oct_q;

    case (state_q)
      ST_CLEAR: begin
        ctl_o.clr_en = 1'b1;
        clr_d = clr_q + 12'd1;
        if (clr_q == 12'(StoreDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd_i == CMD_WRITE) begin
            ctl_o.wr_en = 1'b1;
          end else begin
            ctl_o.load = 1'b1;
            cnt_d  = cnt_cap;
            oct_d  = '0;
            step_d = '0;
            state_d = (cnt_cap == 5'd0) ? ST_FINISH : ST_WRAP;
          end
        end
      end
      ST_WRAP: begin
        ctl_o.wrap_step = 1'b1;
        step_d = step_q + 5'd1;
        if (step_q == 5'(WrapSteps - 1)) begin
          step_d  = '0;
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        ctl_o.wrap_fin = 1'b1;
        state_d = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        ctl_o.sm_stage1 = !step_q[0];
        ctl_o.sm_stage2 = step_q[0];
        step_d = step_q + 5'd1;
        if (step_q == 5'(SmoothSteps - 1)) begin
          step_d  = '0;
          look_d  = '0;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        ctl_o.op = st.op;
        step_d = step_q + 5'd1;
        if (step_q == 5'(LookSteps - 1)) begin
          step_d = '0;
          if (look_q == last_look) begin
            state_d = ST_ADV;
          end else begin
            look_d = look_q + 2'd1;
          end
        end
      end
      ST_ADV: begin
        ctl_o.advance = 1'b1;
        oct_d = oct_q + 4'd1;
        state_d = ({1'b0, oct_q} + 5'd1 == cnt_q) ? ST_FINISH : ST_SMOOTH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR && clr_q == 12'(StoreDepth - 1) |=> state_q == ST_IDLE)
    else $error("clear pass did not end in idle");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH && out_valid_q && !out_ready_i |=> state_q == ST_FINISH)
    else $error("result overwrote a pending transaction");

  a_look_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOK |-> look_q <= last_look)
    else $error("lookup index beyond mode");

  a_query_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cmd_i == CMD_QUERY && cnt_cap != 5'd0 |=> state_q == ST_WRAP)
    else $error("query did not start wrapping");

endmodule

// ----- rtl/lvnt_datapath.sv -----
// lvnt_datapath: lattice memory, coordinate wrap, smoothing, blend stack
// and accumulators; depends on lvnt_pkg, driven by lvnt_ctrl
module lvnt_datapath import lvnt_pkg::*; #(
  parameter int LATTICE_SIZE = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_t               ctl_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [11:0]        entry_index_i,
  input  logic [15:0]        entry_value_i,
  output logic [16:0]        value_x_o,
  output logic [16:0]        value_y_o,
  output logic [16:0]        value_z_o
);

  localparam int CW   = $clog2(LATTICE_SIZE);
  localparam int AW   = $clog2(LATTICE_SIZE * LATTICE_SIZE * LATTICE_SIZE);
  localparam int AXW  = (AW > 12) ? AW : 12;
  localparam int Cube = LATTICE_SIZE * LATTICE_SIZE * LATTICE_SIZE;
  localparam int OffInt = 32768 % LATTICE_SIZE;
  localparam int Kq   = 16 + CW;
  localparam int RecipInt = ((1 << Kq) + LATTICE_SIZE - 1) / LATTICE_SIZE;
  localparam logic [CW:0]    SizeW = LATTICE_SIZE[CW:0];
  localparam logic [CW-1:0]  SizeC = LATTICE_SIZE[CW-1:0];
  localparam logic [CW-1:0]  SizeM1 = CW'(LATTICE_SIZE - 1);
  localparam logic [CW-1:0]  Off   = OffInt[CW-1:0];
  localparam logic [AXW-1:0] SizeA = LATTICE_SIZE[AXW-1:0];
  localparam logic [17:0]    Recip = RecipInt[17:0];

  logic [15:0] mem [StoreDepth];
  logic [15:0] rdata_q;
  logic        rd_ok_q, push_q, lerp_q;

  logic [CW-1:0] cell_q  [3];
  logic [CW-1:0] quo_q   [3];
  logic [15:0]   frac_q  [3];
  logic [15:0]   ubits_q [3];
  logic [16:0]   s_q     [3];
  logic [31:0]   t2_q;
  logic [17:0]   w_q;
  logic [15:0]   stk_q   [4];
  logic signed [34:0] prod_q;
  logic [15:0]   lerp_a_q;
  logic [32:0]   acc_q   [3];
  logic [16:0]   vx_q, vy_q, vz_q;

  logic [31:0]   coord [3];
  logic [33:0]   qprod [3];
  logic [CW-1:0] rmod  [3];
  logic [CW:0]   rem2  [3];
  logic [CW:0]   gsum  [3];
  logic [CW-1:0] g0    [3];
  logic [CW-1:0] g1    [3];
  logic [CW-1:0] gs    [3];
  logic [AXW-1:0] addr;
  logic          in_range;
  logic          wr_ok, mem_we;
  logic [11:0]   mem_waddr;
  logic [15:0]   mem_wdata;
  logic [15:0]   tsel;
  logic [49:0]   sm_full;
  logic [16:0]   s_sel;
  logic signed [16:0] diff;
  logic signed [35:0] lerp_full;
  logic [15:0]   lerp_res;
  logic [4:0]    sh;
  logic [32:0]   addend;

  function automatic logic [16:0] sat_round(input logic [32:0] a);
    logic [33:0] r;
    r = 34'(a) + 34'd32768;
    return (r[33:16] > 18'd131071) ? 17'h1FFFF : r[32:16];
  endfunction

  assign coord[0] = coord_x_i;
  assign coord[1] = coord_y_i;
  assign coord[2] = coord_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qprod[i] = 34'(ubits_q[i]) * 34'(Recip);
      rmod[i]  = ubits_q[i][CW-1:0] - quo_q[i] * SizeC;
      rem2[i]  = {cell_q[i], frac_q[i][15]};
      gsum[i] = {1'b0, cell_q[i]} + (CW + 1)'(ctl_i.look);
      g0[i]   = (gsum[i] >= SizeW) ? CW'(gsum[i] - SizeW) : gsum[i][CW-1:0];
      g1[i]   = (g0[i] == SizeM1) ? '0 : g0[i] + CW'(1);
    end
    gs[0] = ctl_i.corner[2] ? g1[0] : g0[0];
    gs[1] = ctl_i.corner[1] ? g1[1] : g0[1];
    gs[2] = ctl_i.corner[0] ? g1[2] : g0[2];
    addr = (AXW'(gs[0]) * SizeA + AXW'(gs[1])) * SizeA + AXW'(gs[2]);
    in_range = (addr >> 12) == '0;
  end

  assign wr_ok     = 32'(entry_index_i) < Cube;
  assign mem_we    = ctl_i.clr_en || (ctl_i.wr_en && wr_ok);
  assign mem_waddr = ctl_i.clr_en ? ctl_i.clr_addr : entry_index_i;
  assign mem_wdata = ctl_i.clr_en ? 16'h0 : entry_value_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_RD) begin
      rdata_q <= mem[addr[11:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
      push_q  <= 1'b0;
      lerp_q  <= 1'b0;
    end else begin
      rd_ok_q <= in_range;
      push_q  <= (ctl_i.op == OP_RD);
      lerp_q  <= (ctl_i.op == OP_LZ) || (ctl_i.op == OP_LY) || (ctl_i.op == OP_LX);
    end
  end

  // wrap: remainder of the biased integer part, then remove the bias
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (ctl_i.load) begin
        ubits_q[i] <= {~coord[i][31], coord[i][30:16]};
        frac_q[i]  <= coord[i][15:0];
      end else if (ctl_i.wrap_step) begin
        quo_q[i]   <= qprod[i][Kq +: CW];
      end else if (ctl_i.wrap_fin) begin
        cell_q[i]  <= (rmod[i] >= Off) ? rmod[i] - Off
                                       : CW'(SizeW - (CW + 1)'(Off) + (CW + 1)'(rmod[i]));
      end else if (ctl_i.advance) begin
        cell_q[i]  <= (rem2[i] >= SizeW) ? CW'(rem2[i] - SizeW) : rem2[i][CW-1:0];
        frac_q[i]  <= {frac_q[i][14:0], 1'b0};
      end
    end
  end

  // advance reuses rem2 on the fraction msb
  always_comb begin
    case (ctl_i.sm_axis)
      2'd0:    tsel = frac_q[0];
      2'd1:    tsel = frac_q[1];
      default: tsel = frac_q[2];
    endcase
    sm_full = 50'(t2_q) * 50'(w_q) + (50'd1 << 31);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sm_stage1) begin
      t2_q <= 32'(tsel) * 32'(tsel);
      w_q  <= 18'd196608 - {1'b0, tsel, 1'b0};
    end
    if (ctl_i.sm_stage2) begin
      case (ctl_i.sm_axis)
        2'd0:    s_q[0] <= sm_full[48:32];
        2'd1:    s_q[1] <= sm_full[48:32];
        default: s_q[2] <= sm_full[48:32];
      endcase
    end
  end

  always_comb begin
    case (ctl_i.op)
      OP_LX:   s_sel = s_q[0];
      OP_LY:   s_sel = s_q[1];
      default: s_sel = s_q[2];
    endcase
    diff      = $signed({1'b0, stk_q[0]}) - $signed({1'b0, stk_q[1]});
    lerp_full = $signed({4'b0, lerp_a_q, 16'h0}) + 36'(prod_q) + 36'sd32768;
    lerp_res  = lerp_full[31:16];
  end

  always_ff @(posedge clk_i) begin
    if ((ctl_i.op == OP_LZ) || (ctl_i.op == OP_LY) || (ctl_i.op == OP_LX)) begin
      prod_q   <= 35'(diff) * $signed({1'b0, s_sel});
      lerp_a_q <= stk_q[1];
    end
  end

  // operand stack: reads push, a blend pops two and pushes one
  always_ff @(posedge clk_i) begin
    if (push_q) begin
      stk_q[0] <= rd_ok_q ? rdata_q : 16'h0;
      stk_q[1] <= stk_q[0];
      stk_q[2] <= stk_q[1];
      stk_q[3] <= stk_q[2];
    end else if (lerp_q) begin
      stk_q[0] <= lerp_res;
      stk_q[1] <= stk_q[2];
      stk_q[2] <= stk_q[3];
    end
  end

  assign sh     = 5'd16 - {1'b0, ctl_i.oct};
  assign addend = 33'(stk_q[0]) << sh;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= '0;
      end
    end else if (ctl_i.op == OP_ACC) begin
      case (ctl_i.look)
        2'd0:    acc_q[0] <= acc_q[0] + addend;
        2'd1:    acc_q[1] <= acc_q[1] + addend;
        default: acc_q[2] <= acc_q[2] + addend;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      vx_q <= sat_round(acc_q[0]);
      vy_q <= sat_round(acc_q[1]);
      vz_q <= sat_round(acc_q[2]);
    end
  end

  assign value_x_o = vx_q;
  assign value_y_o = vy_q;
  assign value_z_o = vz_q;

endmodule
